@@ rtl/lzssd_pkg.sv @@
// Shared types and constants for the LZSS stream decoder.
`default_nettype none

package lzssd_pkg;

    // Width of one literal token payload
    localparam int LIT_BITS = 8;

    // Initial fill byte of the history window below the start position
    localparam logic [7:0] PAD_BYTE = 8'h20;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] comp_byte;
        logic       stream_end;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic [7:0] plain_byte;
        logic       run_last;
    } t_out;

    // Byte parser control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_DRAIN
    } t_state;

    // Position inside the current token
    typedef enum logic [1:0] {
        TOK_FLAG,
        TOK_LIT,
        TOK_MATCH
    } t_tok;

endpackage

`default_nettype wire

@@ rtl/lzss_stream_decoder.sv @@
// Top level of the LZSS stream decoder: bit parser, copy sequencer and output register.
`default_nettype none

// LZSS decoder with a 2^WINDOW_BITS byte ring window. Each compressed byte is
// parsed one bit per cycle while no completed token waits for the sequencer;
// the input side takes the byte and stays busy until its last bit is parsed.
// A completed token becomes a copy job that emits one decoded byte per cycle
// while the output does not stall, through the window's read and write
// ports: one byte for a literal, length+2 bytes (up to 2^LENGTH_BITS+1) for a
// match, and it runs while the bits of the next token are parsed. A new job
// loads only once the previous job has cleared, so the sequencer idles
// between jobs. A byte that completes a token while the previous job still
// runs waits for that job to finish. With an output that never stalls, a
// byte waits longest when a literal completes soon after a long match. After
// a byte marked stream_end the decoder waits until all its output bytes have
// left the copy path and then returns the window and pointers to their
// initial state; no clearing pass of the memory is needed. Output bytes pass
// through a register; a stall on the output holds the copy path and reaches
// the parser only once a further token completes.
module lzss_stream_decoder #(
    parameter int WINDOW_BITS = 11,
    parameter int LENGTH_BITS = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire lzssd_pkg::t_in  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output lzssd_pkg::t_out      o_out_data
);

    localparam int Depth     = 1 << WINDOW_BITS;
    localparam int MatchBits = WINDOW_BITS + LENGTH_BITS;
    localparam int GatherW   = $clog2(MatchBits + 1);
    localparam int CntW      = LENGTH_BITS + 1;
    localparam logic [WINDOW_BITS-1:0] WpReset =
        WINDOW_BITS'(Depth - (1 << LENGTH_BITS) - 1);

    // Parser state
    lzssd_pkg::t_state      r_state;
    lzssd_pkg::t_state      n_state;
    lzssd_pkg::t_tok        r_tok;
    logic [MatchBits-1:0]   r_shift;
    logic [GatherW-1:0]     r_gath;
    logic [7:0]             r_byte;
    logic [2:0]             r_bits_left;
    logic                   r_end;

    // Copy job
    logic                   r_j_vld;
    logic                   r_j_lit;
    logic [7:0]             r_j_data;
    logic [WINDOW_BITS-1:0] r_j_addr;
    logic [CntW-1:0]        r_j_cnt;

    // Read-data stage and output register
    logic                   r_d_vld;
    logic                   r_d_lit;
    logic [7:0]             r_d_data;
    logic                   r_d_last;
    logic                   r_o_vld;
    lzssd_pkg::t_out        r_o;
    logic [WINDOW_BITS-1:0] r_wp;

    // Combinational control
    logic                   in_acc;
    logic                   bit_now;
    logic [MatchBits-1:0]   sh_next;
    logic [GatherW-1:0]     gath_next;
    logic                   lit_done;
    logic                   match_done;
    logic                   tok_done;
    logic                   bit_step;
    logic                   byte_done;
    logic                   drain_done;
    logic                   job_load;
    logic                   push;
    logic                   issue;
    logic [7:0]             d_byte;
    logic [7:0]             win_rd;

    assign in_acc = i_in_valid && o_in_ready;

    // Token decode of the current bit
    always_comb begin
        bit_now    = r_byte[7];
        sh_next    = {r_shift[MatchBits-2:0], bit_now};
        gath_next  = r_gath + 1'b1;
        lit_done   = (r_tok == lzssd_pkg::TOK_LIT) &&
                     (gath_next == GatherW'(lzssd_pkg::LIT_BITS));
        match_done = (r_tok == lzssd_pkg::TOK_MATCH) &&
                     (gath_next == GatherW'(MatchBits));
        tok_done   = lit_done || match_done;
    end

    // Parser outputs
    always_comb begin
        o_in_ready = (r_state == lzssd_pkg::ST_IDLE);
        bit_step   = (r_state == lzssd_pkg::ST_BITS) && !(tok_done && r_j_vld);
        byte_done  = bit_step && (r_bits_left == 3'd0);
        job_load   = bit_step && tok_done;
        drain_done = (r_state == lzssd_pkg::ST_DRAIN) && !r_j_vld && !r_d_vld;
    end

    // Parser next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzssd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lzssd_pkg::ST_BITS;
                end
            end
            lzssd_pkg::ST_BITS: begin
                if (byte_done) begin
                    n_state = r_end ? lzssd_pkg::ST_DRAIN : lzssd_pkg::ST_IDLE;
                end
            end
            lzssd_pkg::ST_DRAIN: begin
                if (drain_done) begin
                    n_state = lzssd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lzssd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzssd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Byte shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_left <= '0;
            r_end       <= 1'b0;
        end else if (in_acc) begin
            r_byte      <= i_in_data.comp_byte;
            r_end       <= i_in_data.stream_end;
            r_bits_left <= 3'd7;
        end else if (bit_step) begin
            r_byte      <= {r_byte[6:0], 1'b0};
            r_bits_left <= r_bits_left - 1'b1;
        end
    end

    // Token gathering; an unfinished token is dropped at stream end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= lzssd_pkg::TOK_FLAG;
            r_shift <= '0;
            r_gath  <= '0;
        end else if (bit_step) begin
            if (byte_done && r_end) begin
                r_tok   <= lzssd_pkg::TOK_FLAG;
                r_shift <= '0;
                r_gath  <= '0;
            end else begin
                unique case (r_tok)
                    lzssd_pkg::TOK_LIT, lzssd_pkg::TOK_MATCH: begin
                        r_shift <= sh_next;
                        r_gath  <= gath_next;
                        if (tok_done) begin
                            r_tok <= lzssd_pkg::TOK_FLAG;
                        end
                    end
                    default: begin
                        r_tok   <= bit_now ? lzssd_pkg::TOK_LIT : lzssd_pkg::TOK_MATCH;
                        r_shift <= '0;
                        r_gath  <= '0;
                    end
                endcase
            end
        end
    end

    // Copy sequencer: issues one job byte per cycle while the data stage can move
    assign push  = r_d_vld && (!r_o_vld || i_out_ready);
    assign issue = r_j_vld && (!r_d_vld || push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else if (job_load) begin
            r_j_vld  <= 1'b1;
            r_j_lit  <= lit_done;
            r_j_data <= sh_next[7:0];
            r_j_addr <= sh_next[MatchBits-1:LENGTH_BITS];
            r_j_cnt  <= lit_done ? CntW'(1)
                                 : CntW'({1'b0, sh_next[LENGTH_BITS-1:0]}) + CntW'(2);
        end else if (issue) begin
            r_j_addr <= r_j_addr + 1'b1;
            r_j_cnt  <= r_j_cnt - 1'b1;
            if (r_j_cnt == CntW'(1)) begin
                r_j_vld <= 1'b0;
            end
        end
    end

    // Read-data stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= issue || (r_d_vld && !push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_d_lit  <= r_j_lit;
            r_d_data <= r_j_data;
            r_d_last <= (r_j_cnt == CntW'(1));
        end
    end

    assign d_byte = r_d_lit ? r_d_data : win_rd;

    // Write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || drain_done) begin
            r_wp <= WpReset;
        end else if (push) begin
            r_wp <= r_wp + 1'b1;
        end
    end

    lzssd_window #(
        .WINDOW_BITS (WINDOW_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (drain_done),
        .i_rd_en   (issue && !r_j_lit),
        .i_rd_addr (r_j_addr),
        .i_wr_en   (push),
        .i_wr_addr (r_wp),
        .i_wr_data (d_byte),
        .o_rd_data (win_rd)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (push) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_o.plain_byte <= d_byte;
            r_o.run_last   <= r_d_last;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o;

endmodule

`default_nettype wire

@@ rtl/lzssd_window.sv @@
// History window: ring memory with registered read, fill tracking and write forwarding.
`default_nettype none

module lzssd_window #(
    parameter int WINDOW_BITS = 11,
    parameter int LENGTH_BITS = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_clear,
    input  wire logic                   i_rd_en,
    input  wire logic [WINDOW_BITS-1:0] i_rd_addr,
    input  wire logic                   i_wr_en,
    input  wire logic [WINDOW_BITS-1:0] i_wr_addr,
    input  wire logic [7:0]             i_wr_data,
    output logic      [7:0]             o_rd_data
);

    localparam int Depth = 1 << WINDOW_BITS;
    localparam int Base  = Depth - (1 << LENGTH_BITS) - 1;
    localparam logic [WINDOW_BITS-1:0] BaseAddr = WINDOW_BITS'(Base);
    localparam logic [WINDOW_BITS:0]   FillMax  = (WINDOW_BITS + 1)'(Depth);

    logic [7:0]             r_mem [Depth];
    logic [7:0]             r_rd_raw;
    logic                   r_byp;
    logic [7:0]             r_byp_data;
    logic [WINDOW_BITS:0]   r_fill;
    logic [WINDOW_BITS:0]   n_fill;
    logic [WINDOW_BITS-1:0] rd_off;
    logic                   rd_written;
    logic                   rd_hit;
    logic [7:0]             rd_dflt;

    // Memory array: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw <= r_mem[i_rd_addr];
        end
    end

    // Writes go in order from the start position, so a count tells which
    // entries hold data; the rest read as their initial value
    always_comb begin
        n_fill = r_fill;
        if (i_clear) begin
            n_fill = '0;
        end else if (i_wr_en && (r_fill != FillMax)) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Read-side resolution: same-cycle write forwarding, unwritten entries
    assign rd_off     = i_rd_addr - BaseAddr;
    assign rd_written = ({1'b0, rd_off} < r_fill);
    assign rd_hit     = i_wr_en && (i_wr_addr == i_rd_addr);
    assign rd_dflt    = (i_rd_addr < BaseAddr) ? lzssd_pkg::PAD_BYTE : 8'h00;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp      <= rd_hit || !rd_written;
            r_byp_data <= rd_hit ? i_wr_data : rd_dflt;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_raw;

endmodule

`default_nettype wire

@@ rtl/lzssd_checker.sv @@
// Port-level checks for the LZSS stream decoder and their bind.
`default_nettype none

module lzssd_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire lzssd_pkg::t_in  i_in_data,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire lzssd_pkg::t_out o_out_data
);

    // A stalled output transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled output transaction keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An accepted byte occupies the parser for the following cycles
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input taken again while a byte is parsed");

endmodule

bind lzss_stream_decoder lzssd_checker u_lzssd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

@@ dv/tb_lzss_stream_decoder.sv @@
// Self-checking testbench for the LZSS stream decoder: token streams in, predicted bytes out.
module tb_lzss_stream_decoder;

    localparam int WIN_BITS    = 11;
    localparam int LEN_BITS    = 5;
    localparam int WIN_SIZE    = 1 << WIN_BITS;
    localparam int LOOKAHEAD   = (1 << LEN_BITS) + 1;
    localparam int MATCH_BITS  = WIN_BITS + LEN_BITS;
    localparam int MAX_CODE    = (1 << LEN_BITS) - 1;
    localparam int START_PTR   = WIN_SIZE - LOOKAHEAD;
    localparam int RUN_LIMIT   = 400000;
    localparam int TAIL_CYCLES = 64;

    // Predicts decoded bytes from accepted compressed bytes and checks them in order
    class decode_scoreboard;
        bit [7:0]            history [WIN_SIZE];
        bit [WIN_BITS-1:0]   wr_ptr;
        bit [MATCH_BITS-1:0] token_bits;
        int unsigned         bit_count;
        lzssd_pkg::t_tok     phase;
        bit [7:0]            run_bytes[$];
        lzssd_pkg::t_out     plain_q[$];
        int unsigned         bytes_in;
        int unsigned         streams_seen;
        int unsigned         bytes_checked;

        function new();
            restart();
        endfunction

        // Window back to the initial fill, parser back to awaiting a flag
        function void restart();
            for (int i = 0; i < WIN_SIZE; i++)
                history[i] = (i < START_PTR) ? lzssd_pkg::PAD_BYTE : 8'h00;
            wr_ptr     = WIN_BITS'(START_PTR);
            token_bits = '0;
            bit_count  = 0;
            phase      = lzssd_pkg::TOK_FLAG;
        endfunction

        function void record_byte(bit [7:0] c);
            history[wr_ptr] = c;
            wr_ptr++;
            run_bytes.push_back(c);
        endfunction

        function void take_compressed(lzssd_pkg::t_in item);
            bit [WIN_BITS-1:0] src;
            int unsigned       run_len;
            lzssd_pkg::t_out   res;
            bytes_in++;
            for (int b = 7; b >= 0; b--) begin
                if (phase == lzssd_pkg::TOK_FLAG) begin
                    phase      = item.comp_byte[b] ? lzssd_pkg::TOK_LIT : lzssd_pkg::TOK_MATCH;
                    token_bits = '0;
                    bit_count  = 0;
                end else begin
                    token_bits = {token_bits[MATCH_BITS-2:0], item.comp_byte[b]};
                    bit_count++;
                    if (phase == lzssd_pkg::TOK_LIT && bit_count == lzssd_pkg::LIT_BITS) begin
                        record_byte(token_bits[7:0]);
                        phase = lzssd_pkg::TOK_FLAG;
                    end else if (phase == lzssd_pkg::TOK_MATCH &&
                                 bit_count == MATCH_BITS) begin
                        src     = token_bits[MATCH_BITS-1 -: WIN_BITS];
                        run_len = token_bits[LEN_BITS-1:0] + 2;
                        // reads follow writes, so overlapping copies repeat fresh bytes
                        for (int k = 0; k < run_len; k++) begin
                            record_byte(history[src]);
                            src++;
                        end
                        phase = lzssd_pkg::TOK_FLAG;
                    end
                end
            end
            foreach (run_bytes[i]) begin
                res.plain_byte = run_bytes[i];
                res.run_last   = (i == run_bytes.size() - 1);
                plain_q.push_back(res);
            end
            run_bytes.delete();
            if (item.stream_end) begin
                streams_seen++;
                restart();
            end
        endfunction

        // Empty string when the byte matches the oldest prediction
        function string check_plain(lzssd_pkg::t_out got);
            lzssd_pkg::t_out want;
            if (plain_q.size() == 0)
                return $sformatf("unexpected output byte %02h run_last %0b",
                                 got.plain_byte, got.run_last);
            want = plain_q.pop_front();
            bytes_checked++;
            if (got.plain_byte !== want.plain_byte || got.run_last !== want.run_last)
                return $sformatf("output %0d: plain_byte %02h exp %02h, run_last %0b exp %0b",
                                 bytes_checked, got.plain_byte, want.plain_byte,
                                 got.run_last, want.run_last);
            return "";
        endfunction

        function int pending();
            return plain_q.size();
        endfunction
    endclass

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    lzssd_pkg::t_in  i_in_data   = '0;
    logic            i_out_ready = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    lzssd_pkg::t_out o_out_data;

    decode_scoreboard sb;
    lzssd_pkg::t_in   send_q[$];
    bit               stream_bits[$];
    int               gen_wp = START_PTR;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               errors = 0;
    int               cycle_count = 0;
    int               send_pcts[4] = '{0, 83, 0, 12};
    int               recv_pcts[4] = '{0, 0, 83, 12};

    lzss_stream_decoder #(
        .WINDOW_BITS(WIN_BITS),
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 30)
            $display("MISMATCH: %s", msg);
    endtask

    // Token stream builder
    function automatic void push_field(int unsigned value, int width);
        for (int i = width - 1; i >= 0; i--)
            stream_bits.push_back(value[i]);
    endfunction

    function automatic void add_literal(bit [7:0] c);
        push_field(1, 1);
        push_field(c, 8);
        gen_wp = (gen_wp + 1) % WIN_SIZE;
    endfunction

    function automatic void add_match(int unsigned pos, int unsigned code);
        push_field(0, 1);
        push_field(pos, WIN_BITS);
        push_field(code, LEN_BITS);
        gen_wp = (gen_wp + code + 2) % WIN_SIZE;
    endfunction

    function automatic int unsigned recent_pos(int unsigned back);
        return (gen_wp + WIN_SIZE - back) % WIN_SIZE;
    endfunction

    // Pad with random bits to a byte boundary and mark the final byte
    function automatic void close_stream();
        lzssd_pkg::t_in item;
        while (stream_bits.size() % 8 != 0)
            stream_bits.push_back(1'($urandom_range(0, 1)));
        for (int i = 0; i < stream_bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++)
                item.comp_byte[7-j] = stream_bits[i+j];
            item.stream_end = (i + 8 == stream_bits.size());
            send_q.push_back(item);
        end
        stream_bits.delete();
        gen_wp = START_PTR;
    endfunction

    // Mostly well-formed token streams, now and then raw noise bytes
    function automatic void add_random_stream();
        int unsigned    edges[4] = '{0, WIN_SIZE - 1, START_PTR - 1, START_PTR};
        int unsigned    n;
        lzssd_pkg::t_in item;
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                item.comp_byte  = 8'($urandom);
                item.stream_end = (i == n - 1);
                send_q.push_back(item);
            end
            return;
        end
        n = $urandom_range(1, 8);
        for (int t = 0; t < n; t++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_literal(8'($urandom));
                4, 5, 6:    add_match(recent_pos($urandom_range(1, 34)),
                                      $urandom_range(0, MAX_CODE));
                7:          add_match($urandom_range(0, WIN_SIZE - 1), $urandom_range(0, MAX_CODE));
                8:          add_match(edges[$urandom_range(0, 3)], $urandom_range(0, MAX_CODE));
                default:    add_match($urandom_range(0, WIN_SIZE - 1),
                                      $urandom_range(0, 1) ? MAX_CODE : 0);
            endcase
        end
        // sometimes leave an unfinished token for the end of stream
        if ($urandom_range(0, 3) == 0) begin
            push_field($urandom_range(0, 1), 1);
            push_field($urandom, $urandom_range(0, 6));
        end
        close_stream();
    endfunction

    // Send every queued transaction, idling between them at the current rate
    task automatic drive_items();
        int gap;
        while (send_q.size() != 0) begin
            gap = 0;
            while ($urandom_range(0, 99) < send_idle_pct)
                gap++;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= send_q.pop_front();
            do @(posedge i_clk); while (!o_in_ready);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Observe both channels, then pick the next receiver ready
    always @(posedge i_clk) begin : monitor
        string msg;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.take_compressed(i_in_data);
            if (o_out_valid && i_out_ready) begin
                msg = sb.check_plain(o_out_data);
                if (msg != "")
                    report_mismatch(msg);
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Literal extremes, matches across the fill boundary, wrap and overlap
        add_literal(8'h00);
        add_literal(8'hFF);
        add_match(START_PTR - 1, 0);
        add_match(START_PTR, MAX_CODE);
        add_match(0, MAX_CODE);
        add_match(WIN_SIZE - 1, 5);
        add_match(recent_pos(1), 10);
        add_literal(8'h5A);
        // unfinished match in the final byte is dropped
        push_field(0, 1);
        push_field($urandom, 4);
        close_stream();
        // match that completes exactly in the final byte
        for (int i = 0; i < 7; i++)
            add_literal(8'($urandom));
        add_match(recent_pos(3), $urandom_range(0, MAX_CODE));
        close_stream();
        drive_items();
        wait_drained();

        // Random streams under each idle mode; sender holds off until drained
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            while (send_q.size() < 22)
                add_random_stream();
            drive_items();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d decoded bytes never arrived", sb.pending()));

        $display("Run covered %0d streams, %0d compressed bytes, %0d decoded bytes checked",
                 sb.streams_seen, sb.bytes_in, sb.bytes_checked);
        $display("Idle modes: none, sender 83 pct, receiver 83 pct, both 12 pct");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lzssd_pkg.sv
rtl/lzssd_window.sv
rtl/lzss_stream_decoder.sv
rtl/lzssd_checker.sv
dv/tb_lzss_stream_decoder.sv
